// ----- rtl/pba_pkg.sv -----
package pba_pkg;

    localparam int SIZE_W   = 21;
    localparam int SLOT_W   = 4;
    localparam int OFFSET_W = 20;

    // Register index of page_size on the configuration port
    localparam int REG_PAGE_SIZE = 0;

    typedef enum logic [0:0] {
        KIND_ALLOC   = 1'b0,
        KIND_RELEASE = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_SLOT  = 3'd4,
        ST_DEAD_OVF  = 3'd5
    } t_status;

    // One page slot as held in the slot memory
    typedef struct packed {
        logic [SIZE_W-1:0] page;
        logic [SIZE_W-1:0] free;
        logic [SIZE_W-1:0] dead;
    } t_page_entry;

    // Controller to datapath
    typedef struct packed {
        logic    load_in;
        logic    mul1;
        logic    mul2;
        logic    scan_start;
        logic    scan_step;
        logic    alloc_hit;
        logic    alloc_open;
        logic    rel_read;
        logic    rel_commit;
        logic    err;
        t_status err_code;
        logic    out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_release;
        logic zero;
        logic too_large;
        logic slot_bad;
        logic hit;
        logic scan_end;
        logic free_any;
    } t_dp_stat;

endpackage

// ----- rtl/pba_ram.sv -----
module pba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pba_dp.sv -----
module pba_dp
    import pba_pkg::*;
#(
    parameter int MAX_PAGES   = 16,
    parameter int ELEM_STRIDE = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic                i_kind,
    input  logic [SIZE_W-1:0]   i_size_bytes,
    input  logic [SLOT_W-1:0]   i_page_slot,
    input  logic [SIZE_W-1:0]   i_page_size,
    output logic [2:0]          o_status,
    output logic [SLOT_W-1:0]   o_granted_slot,
    output logic [OFFSET_W-1:0] o_offset,
    output logic [SIZE_W-1:0]   o_granted_size,
    output logic                o_page_opened,
    output logic                o_page_freed
);

    localparam int SW          = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int RECIP_SHIFT = 30;
    // ceil(2^30 / stride): exact quotient for any dividend below 2^22
    localparam longint unsigned RecipL =
        ((64'd1 << RECIP_SHIFT) + ELEM_STRIDE - 1) / ELEM_STRIDE;
    localparam logic [30:0]   RECIP  = 31'(RecipL);
    localparam logic [21:0]   BIAS   = 22'(ELEM_STRIDE - 1);
    localparam logic [8:0]    STRIDE = 9'(ELEM_STRIDE);
    localparam logic [8:0]    PAGES  = 9'(MAX_PAGES);
    localparam logic [SW-1:0] LAST   = SW'(MAX_PAGES - 1);

    t_kind               r_kind;
    logic [SIZE_W-1:0]   r_size;
    logic [SLOT_W-1:0]   r_slot;
    logic [21:0]         r_quot;
    logic [21:0]         r_rounded;
    logic [MAX_PAGES-1:0] r_valid;
    logic [SW-1:0]       r_scan_idx;
    logic [SW-1:0]       r_cmp_idx;
    logic [SW-1:0]       r_free_idx;
    logic                r_free_any;

    t_status             r_res_status;
    logic [SLOT_W-1:0]   r_res_slot;
    logic [OFFSET_W-1:0] r_res_offset;
    logic [SIZE_W-1:0]   r_res_size;
    logic                r_res_opened;
    logic                r_res_freed;

    logic [2:0]          r_o_status;
    logic [SLOT_W-1:0]   r_o_slot;
    logic [OFFSET_W-1:0] r_o_offset;
    logic [SIZE_W-1:0]   r_o_size;
    logic                r_o_opened;
    logic                r_o_freed;

    logic [21:0]         w_biased;
    logic [52:0]         w_prod;
    logic [30:0]         w_mult;
    logic [SW-1:0]       w_slot_idx;
    logic [SIZE_W-1:0]   w_rounded;
    t_page_entry         w_rd;
    t_page_entry         w_wdata;
    logic [SW-1:0]       w_waddr;
    logic [SW-1:0]       w_raddr;
    logic                w_we;
    logic [21:0]         w_dead_sum;
    logic [SIZE_W-1:0]   w_dead_sat;
    logic                w_dead_ovf;
    logic                w_freed;

    assign w_biased   = 22'(r_size) + BIAS;
    assign w_prod     = 53'(w_biased) * 53'(RECIP);
    assign w_mult     = 31'(r_quot) * 31'(STRIDE);
    assign w_slot_idx = SW'(r_slot);
    assign w_rounded  = r_rounded[SIZE_W-1:0];

    // Release arithmetic: saturate the dead count to the field width
    assign w_dead_sum = 22'(w_rd.dead) + 22'(r_size);
    assign w_dead_sat = w_dead_sum[21] ? {SIZE_W{1'b1}} : w_dead_sum[SIZE_W-1:0];
    assign w_dead_ovf = w_dead_sat > w_rd.page;
    assign w_freed    = !w_dead_ovf && (w_dead_sat == (w_rd.page - w_rd.free));

    always_comb begin
        priority if (i_cmd.scan_start) begin
            w_raddr = LAST;
        end else if (i_cmd.rel_read) begin
            w_raddr = w_slot_idx;
        end else begin
            w_raddr = r_scan_idx;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cmp_idx;
        w_wdata = w_rd;
        priority if (i_cmd.alloc_hit) begin
            w_we         = 1'b1;
            w_wdata.free = w_rd.free - w_rounded;
        end else if (i_cmd.alloc_open && r_free_any) begin
            w_we         = 1'b1;
            w_waddr      = r_free_idx;
            w_wdata.page = i_page_size;
            w_wdata.free = i_page_size - w_rounded;
            w_wdata.dead = '0;
        end else if (i_cmd.rel_commit) begin
            w_we         = 1'b1;
            w_waddr      = w_slot_idx;
            w_wdata.dead = w_dead_sat;
        end else begin
            w_we = 1'b0;
        end
    end

    pba_ram #(
        .WIDTH ($bits(t_page_entry)),
        .DEPTH (MAX_PAGES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_free_any <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_free_any <= 1'b0;
            end else if (i_cmd.scan_step && !r_valid[r_cmp_idx]) begin
                r_free_any <= 1'b1;
            end
            if (i_cmd.alloc_open && r_free_any) begin
                r_valid[r_free_idx] <= 1'b1;
            end else if (i_cmd.rel_commit && w_freed) begin
                r_valid[w_slot_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind <= t_kind'(i_kind);
            r_size <= i_size_bytes;
            r_slot <= i_page_slot;
        end
        if (i_cmd.mul1) begin
            r_quot <= w_prod[RECIP_SHIFT +: 22];
        end
        if (i_cmd.mul2) begin
            r_rounded <= w_mult[21:0];
        end
        // Scan from the top slot down; the lowest empty slot is the last one seen
        if (i_cmd.scan_start) begin
            r_cmp_idx  <= LAST;
            r_scan_idx <= LAST - SW'(1);
        end else if (i_cmd.scan_step) begin
            r_cmp_idx  <= r_scan_idx;
            r_scan_idx <= r_scan_idx - SW'(1);
            if (!r_valid[r_cmp_idx]) begin
                r_free_idx <= r_cmp_idx;
            end
        end

        priority if (i_cmd.err || (i_cmd.alloc_open && !r_free_any)) begin
            r_res_status <= i_cmd.alloc_open ? ST_FULL : i_cmd.err_code;
            r_res_slot   <= '0;
            r_res_offset <= '0;
            r_res_size   <= '0;
            r_res_opened <= 1'b0;
            r_res_freed  <= 1'b0;
        end else if (i_cmd.alloc_hit) begin
            r_res_status <= ST_OK;
            r_res_slot   <= SLOT_W'(r_cmp_idx);
            r_res_offset <= OFFSET_W'(w_rd.page - w_rd.free);
            r_res_size   <= w_rounded;
            r_res_opened <= 1'b0;
            r_res_freed  <= 1'b0;
        end else if (i_cmd.alloc_open) begin
            r_res_status <= ST_OK;
            r_res_slot   <= SLOT_W'(r_free_idx);
            r_res_offset <= '0;
            r_res_size   <= w_rounded;
            r_res_opened <= 1'b1;
            r_res_freed  <= 1'b0;
        end else if (i_cmd.rel_commit) begin
            r_res_status <= w_dead_ovf ? ST_DEAD_OVF : ST_OK;
            r_res_slot   <= '0;
            r_res_offset <= '0;
            r_res_size   <= '0;
            r_res_opened <= 1'b0;
            r_res_freed  <= w_freed;
        end else begin
            r_res_status <= r_res_status;
        end

        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_slot   <= r_res_slot;
            r_o_offset <= r_res_offset;
            r_o_size   <= r_res_size;
            r_o_opened <= r_res_opened;
            r_o_freed  <= r_res_freed;
        end
    end

    assign o_stat.is_release = (r_kind == KIND_RELEASE);
    assign o_stat.zero       = (r_size == '0);
    assign o_stat.too_large  = r_rounded > 22'(i_page_size);
    assign o_stat.slot_bad   = (9'(r_slot) >= PAGES) || !r_valid[w_slot_idx];
    assign o_stat.hit        = r_valid[r_cmp_idx] && (22'(w_rd.free) >= r_rounded);
    assign o_stat.scan_end   = (r_cmp_idx == '0);
    assign o_stat.free_any   = r_free_any;

    assign o_status       = r_o_status;
    assign o_granted_slot = r_o_slot;
    assign o_offset       = r_o_offset;
    assign o_granted_size = r_o_size;
    assign o_page_opened  = r_o_opened;
    assign o_page_freed   = r_o_freed;

endmodule

// ----- rtl/pba_ctrl.sv -----
module pba_ctrl
    import pba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_CHECK,
        S_SCAN,
        S_OPEN,
        S_REL,
        S_DONE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_o_valid;
    logic    n_o_valid;
    t_dp_cmd w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_cmd.load_in = 1'b1;
                    n_state       = S_MUL1;
                end
            end
            S_MUL1: begin
                w_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                w_cmd.mul2 = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                priority if (i_stat.zero) begin
                    w_cmd.err      = 1'b1;
                    w_cmd.err_code = ST_ZERO;
                    n_state        = S_DONE;
                end else if (i_stat.is_release && i_stat.slot_bad) begin
                    w_cmd.err      = 1'b1;
                    w_cmd.err_code = ST_BAD_SLOT;
                    n_state        = S_DONE;
                end else if (i_stat.is_release) begin
                    w_cmd.rel_read = 1'b1;
                    n_state        = S_REL;
                end else if (i_stat.too_large) begin
                    w_cmd.err      = 1'b1;
                    w_cmd.err_code = ST_TOO_LARGE;
                    n_state        = S_DONE;
                end else begin
                    w_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                w_cmd.scan_step = 1'b1;
                priority if (i_stat.hit) begin
                    w_cmd.alloc_hit = 1'b1;
                    n_state         = S_DONE;
                end else if (i_stat.scan_end) begin
                    n_state = S_OPEN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_OPEN: begin
                w_cmd.alloc_open = 1'b1;
                n_state          = S_DONE;
            end
            S_REL: begin
                w_cmd.rel_commit = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (w_cmd.out_load) begin
            n_o_valid = 1'b1;
        end else if (!i_stall) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;
    assign o_cmd   = w_cmd;

endmodule

// ----- rtl/paged_bump_allocator.sv -----
// Paged bump allocator. Keeps MAX_PAGES page slots, each with a size, a free-byte
// count and a dead-byte count. An allocate transaction rounds its size up to
// ELEM_STRIDE, takes the highest-numbered valid page with room, or else opens the
// lowest empty slot as a fresh page of page_size bytes, and bumps the page's
// offset. A release transaction adds its size to the page's dead bytes and frees
// the page once the dead bytes match the bytes handed out. One transaction is in
// work at a time; a finished result sits in the output register, so the next
// input is taken while it waits. A transaction steps through rounding and the
// checks; a rejected one goes straight to the hand-off, a release updates its
// slot, and an allocate scans the slots, one slot per cycle through the read port
// of the slot memory, and takes an open step when no page has room. The result
// then passes to the output register. page_size is written over an APB port at
// byte address 0 (bit 2 of paddr set selects nothing) and may only change while
// no transaction is in work.
module paged_bump_allocator
    import pba_pkg::*;
#(
    parameter int MAX_PAGES   = 16,
    parameter int ELEM_STRIDE = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // request channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_kind,
    input  logic [SIZE_W-1:0]   i_size_bytes,
    input  logic [SLOT_W-1:0]   i_page_slot,

    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic [SLOT_W-1:0]   o_granted_slot,
    output logic [OFFSET_W-1:0] o_offset,
    output logic [SIZE_W-1:0]   o_granted_size,
    output logic                o_page_opened,
    output logic                o_page_freed,

    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic [SIZE_W-1:0] PAGE_SIZE_RST = 21'd65536;

    logic [SIZE_W-1:0] r_page_size;
    logic              w_cfg_sel;
    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;

    // Only one register: word 0. Ignore the byte lane bits.
    assign w_cfg_sel = (paddr[2] == 1'(REG_PAGE_SIZE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size <= PAGE_SIZE_RST;
        end else if (psel && penable && pwrite && w_cfg_sel) begin
            r_page_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign prdata = w_cfg_sel ? 32'(r_page_size) : '0;
    assign pready = 1'b1;

    // Sequence the transaction: rounding, checks, slot scan, update, hand-off
    pba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    // Slot memory, valid marks, rounding multipliers and the result registers
    pba_dp #(
        .MAX_PAGES   (MAX_PAGES),
        .ELEM_STRIDE (ELEM_STRIDE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_kind         (i_kind),
        .i_size_bytes   (i_size_bytes),
        .i_page_slot    (i_page_slot),
        .i_page_size    (r_page_size),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot),
        .o_offset       (o_offset),
        .o_granted_size (o_granted_size),
        .o_page_opened  (o_page_opened),
        .o_page_freed   (o_page_freed)
    );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import pba_pkg::*;

    // Block build: sixteen page slots, sixteen-byte element stride
    localparam int          MAX_PAGES     = 16;
    localparam int          ELEM_STRIDE   = 16;
    localparam int unsigned SIZE_SAT      = 32'h1F_FFFF;
    localparam int unsigned SIZE_TOP      = 32'd1048576;
    localparam logic [2:0]  PAGE_SIZE_ADDR = 3'(4 * REG_PAGE_SIZE);

    // Opening a page scans every slot, so the settle time leaves margin on top
    localparam int SETTLE_CYCLES   = 30;
    localparam int STALL_LIMIT     = 2000;
    localparam int PRESSURE_CYCLES = 120;
    localparam int PHASE_ITEMS     = 225;
    localparam int PHASES          = 6;

    // Page size per random phase: smallest page, largest page, and a spread between
    localparam int unsigned PHASE_PAGE [PHASES] = '{16, 1048576, 256, 65536, 4096, 48};

    // One result transaction as seen on the output ports
    typedef struct packed {
        logic [2:0]          status;
        logic [SLOT_W-1:0]   slot;
        logic [OFFSET_W-1:0] offset;
        logic [SIZE_W-1:0]   gsize;
        logic                opened;
        logic                freed;
    } t_alloc_resp;

    // A granted block that has not been released yet
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [SIZE_W-1:0] nbytes;
    } t_live_block;

    // Page table mirror: predicts each response at acceptance and queues it
    class alloc_scoreboard;
        int unsigned page_size;
        bit          page_valid [MAX_PAGES];
        int unsigned page_bytes [MAX_PAGES];
        int unsigned free_bytes [MAX_PAGES];
        int unsigned dead_bytes [MAX_PAGES];
        t_alloc_resp resp_q [$];
        t_live_block live_q [$];
        int          err_count;

        function new();
            page_size = 65536;
            err_count = 0;
            foreach (page_valid[i]) page_valid[i] = 1'b0;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            err_count++;
        endtask

        function void note_request(t_kind kind, logic [SIZE_W-1:0] nbytes,
                                   logic [SLOT_W-1:0] slot);
            t_alloc_resp r;
            t_live_block blk;
            int unsigned rounded;
            int unsigned dead_sum;
            int          found;
            r = '0;
            found = -1;
            if (nbytes == 0) begin
                r.status = ST_ZERO;
            end else if (kind == KIND_ALLOC) begin
                rounded = ((int'(nbytes) + ELEM_STRIDE - 1) / ELEM_STRIDE) * ELEM_STRIDE;
                if (rounded > page_size) begin
                    r.status = ST_TOO_LARGE;
                end else begin
                    for (int i = MAX_PAGES - 1; i >= 0; i--)
                        if (found < 0 && page_valid[i] && free_bytes[i] >= rounded)
                            found = i;
                    if (found < 0) begin
                        for (int i = 0; i < MAX_PAGES; i++)
                            if (found < 0 && !page_valid[i]) found = i;
                        if (found >= 0) begin
                            page_valid[found] = 1'b1;
                            page_bytes[found] = page_size;
                            free_bytes[found] = page_size;
                            dead_bytes[found] = 0;
                            r.opened = 1'b1;
                        end
                    end
                    if (found < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        r.status = ST_OK;
                        r.slot   = SLOT_W'(found);
                        r.offset = OFFSET_W'(page_bytes[found] - free_bytes[found]);
                        r.gsize  = SIZE_W'(rounded);
                        free_bytes[found] -= rounded;
                        blk.slot   = SLOT_W'(found);
                        blk.nbytes = SIZE_W'(rounded);
                        live_q.push_back(blk);
                    end
                end
            end else if (!page_valid[slot]) begin
                r.status = ST_BAD_SLOT;
            end else begin
                dead_sum = dead_bytes[slot] + nbytes;
                if (dead_sum > SIZE_SAT) dead_sum = SIZE_SAT;
                dead_bytes[slot] = dead_sum;
                if (dead_sum > page_bytes[slot]) begin
                    r.status = ST_DEAD_OVF;
                end else begin
                    r.status = ST_OK;
                    if (dead_sum == page_bytes[slot] - free_bytes[slot]) begin
                        page_valid[slot] = 1'b0;
                        r.freed = 1'b1;
                        // blocks still listed in a freed page can no longer be released
                        for (int k = live_q.size() - 1; k >= 0; k--)
                            if (live_q[k].slot == slot) live_q.delete(k);
                    end
                end
            end
            resp_q.push_back(r);
        endfunction

        task check_result(t_alloc_resp got);
            t_alloc_resp want;
            if (resp_q.size() == 0) begin
                report($sformatf("result with status %0d and no request waiting", got.status));
                return;
            end
            want = resp_q.pop_front();
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.slot !== want.slot)
                report($sformatf("granted_slot got %0d want %0d", got.slot, want.slot));
            if (got.offset !== want.offset)
                report($sformatf("offset got %0d want %0d", got.offset, want.offset));
            if (got.gsize !== want.gsize)
                report($sformatf("granted_size got %0d want %0d", got.gsize, want.gsize));
            if (got.opened !== want.opened)
                report($sformatf("page_opened got %0b want %0b", got.opened, want.opened));
            if (got.freed !== want.freed)
                report($sformatf("page_freed got %0b want %0b", got.freed, want.freed));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_kind;
    logic [SIZE_W-1:0]   i_size_bytes;
    logic [SLOT_W-1:0]   i_page_slot;
    logic                o_valid;
    logic                i_stall;
    logic [2:0]          o_status;
    logic [SLOT_W-1:0]   o_granted_slot;
    logic [OFFSET_W-1:0] o_offset;
    logic [SIZE_W-1:0]   o_granted_size;
    logic                o_page_opened;
    logic                o_page_freed;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    alloc_scoreboard sb;
    int              tx_idle_pct;
    int              rx_idle_pct;
    bit              hold_req;

    paged_bump_allocator #(
        .MAX_PAGES   (MAX_PAGES),
        .ELEM_STRIDE (ELEM_STRIDE)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_size_bytes   (i_size_bytes),
        .i_page_slot    (i_page_slot),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot),
        .o_offset       (o_offset),
        .o_granted_size (o_granted_size),
        .o_page_opened  (o_page_opened),
        .o_page_freed   (o_page_freed),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Offer one request transaction, idling first at the sender's rate, and hold it
    // until the block takes it. Valid stays high on return so that a back-to-back
    // transaction needs only one assignment in the acceptance step.
    task automatic send_request(input t_kind kind, input logic [SIZE_W-1:0] nbytes,
                                input logic [SLOT_W-1:0] slot);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_size_bytes <= nbytes;
        i_page_slot  <= slot;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(kind, nbytes, slot);
    endtask

    // Drop valid, collect every outstanding response, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.resp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write page_size over APB once the block is idle, then read it back
    task automatic write_page_size(input int unsigned value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PAGE_SIZE_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.page_size = value;
        // keep psel high and turn straight into a read setup
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[SIZE_W-1:0] !== value[SIZE_W-1:0])
            sb.report($sformatf("page_size read back %0d want %0d",
                                prdata[SIZE_W-1:0], value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly well-formed traffic: release of a live block (more likely the more
    // blocks are live, which holds the live count back), allocations of mixed
    // sizes, and a thin layer of broken releases.
    task automatic random_request();
        t_live_block        blk;
        int                 pick;
        int unsigned        nbytes;
        int unsigned        top;
        logic [SLOT_W-1:0]  slot;
        int                 empty_slots [$];
        if (sb.live_q.size() > 0 && $urandom_range(0, 31) < sb.live_q.size()) begin
            pick = $urandom_range(0, sb.live_q.size() - 1);
            blk  = sb.live_q[pick];
            sb.live_q.delete(pick);
            send_request(KIND_RELEASE, blk.nbytes, blk.slot);
        end else if ($urandom_range(0, 99) < 6) begin
            for (int i = 0; i < MAX_PAGES; i++)
                if (!sb.page_valid[i]) empty_slots.push_back(i);
            pick = $urandom_range(0, 9);
            slot = SLOT_W'($urandom_range(0, MAX_PAGES - 1));
            if (pick == 0)
                send_request(KIND_RELEASE, '0, slot);
            else if (pick == 9)
                // a stray stride-sized release into whatever page sits there
                send_request(KIND_RELEASE, SIZE_W'(ELEM_STRIDE), slot);
            else if (empty_slots.size() > 0)
                send_request(KIND_RELEASE, SIZE_W'($urandom_range(1, SIZE_TOP)),
                             SLOT_W'(empty_slots[$urandom_range(0, empty_slots.size() - 1)]));
            else
                send_request(KIND_RELEASE, '0, slot);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                nbytes = 0;
            else if (pick < 7)
                nbytes = (sb.page_size < SIZE_TOP)
                         ? $urandom_range(sb.page_size + 1, SIZE_TOP) : SIZE_TOP;
            else if (pick < 10)
                nbytes = SIZE_TOP;
            else if (pick < 45)
                nbytes = $urandom_range(1, 64);
            else begin
                top    = sb.page_size >> $urandom_range(0, 4);
                nbytes = $urandom_range(1, (top == 0) ? 1 : top);
            end
            send_request(KIND_ALLOC, nbytes[SIZE_W-1:0],
                         SLOT_W'($urandom_range(0, MAX_PAGES - 1)));
        end
    endtask

    // Receiver: take result transactions at the current stall rate. On request, hold
    // off for a long stretch so that the block backs up and stalls its input.
    initial begin
        int unsigned hold_left;
        t_alloc_resp got;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.status = o_status;
                got.slot   = o_granted_slot;
                got.offset = o_offset;
                got.gsize  = o_granted_size;
                got.opened = o_page_opened;
                got.freed  = o_page_freed;
                sb.check_result(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = PRESSURE_CYCLES;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either channel for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        sb           = new();
        hold_req     = 1'b0;
        tx_idle_pct  = 27;
        rx_idle_pct  = 64;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_kind       = KIND_ALLOC;
        i_size_bytes = '0;
        i_page_slot  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset page size of 64 KiB.
        // Zero-size allocate and release: rejected, nothing changes.
        send_request(KIND_ALLOC, '0, 4'd0);
        send_request(KIND_RELEASE, '0, 4'd3);
        // Release into slots never opened, including the top slot and largest size
        send_request(KIND_RELEASE, 21'd16, 4'd5);
        send_request(KIND_RELEASE, SIZE_W'(SIZE_TOP), 4'd15);
        // Too large: just past the page, and the largest request
        send_request(KIND_ALLOC, 21'd65537, 4'd0);
        send_request(KIND_ALLOC, SIZE_W'(SIZE_TOP), 4'd9);
        // Open slot 0, round 1 up and 17 up, then a full page that must open slot 1
        send_request(KIND_ALLOC, 21'd1, 4'd0);
        send_request(KIND_ALLOC, 21'd17, 4'd15);
        send_request(KIND_ALLOC, 21'd65536, 4'd0);
        // Slot 1 is full, so this one falls back to slot 0
        send_request(KIND_ALLOC, 21'd48, 4'd0);
        // Free slot 1 in one go, then slot 0 over three releases
        send_request(KIND_RELEASE, 21'd65536, 4'd1);
        send_request(KIND_RELEASE, 21'd16, 4'd0);
        send_request(KIND_RELEASE, 21'd32, 4'd0);
        send_request(KIND_RELEASE, 21'd48, 4'd0);
        // Reopen slot 0 as a full page, then overflow its dead bytes twice; the
        // second overflow runs into the 21-bit saturation of the dead count
        send_request(KIND_ALLOC, 21'd65536, 4'd0);
        send_request(KIND_RELEASE, SIZE_W'(SIZE_TOP), 4'd0);
        send_request(KIND_RELEASE, SIZE_W'(SIZE_TOP), 4'd0);

        // Random phases: receiver idles more at first, then the sender, then neither
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 2) begin
                tx_idle_pct = 64;
                rx_idle_pct = 27;
            end else if (ph == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_page_size(PHASE_PAGE[ph]);
            if (ph == 4) hold_req = 1'b1;
            repeat (PHASE_ITEMS) random_request();
        end

        drain();
        if (sb.resp_q.size() != 0)
            sb.report($sformatf("%0d responses never arrived", sb.resp_q.size()));
        if (sb.err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
